>>> sv/rcpw_pkg.sv
`timescale 1ns / 1ps

package rcpw_pkg;

	localparam int NUM_LINES = 5;
	localparam int CHANNELS = 5;
	localparam int USED_CHANNELS = (CHANNELS < NUM_LINES) ? CHANNELS : NUM_LINES;
	localparam int TICKS_PER_MICROSECOND = 40;

	localparam int CH_BITS = 3;
	localparam int PIN_BITS = 5;
	localparam int TICK_BITS = 32;
	localparam int WIDTH_BITS = 16;

	localparam logic [CH_BITS-1:0] NO_CHANNEL = 3'd5;
	localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 16'hFFFF;

	// pin bit of each channel, in priority order
	localparam logic [PIN_BITS-1:0] CHAN_MASK [NUM_LINES] = '{
		5'b00100,   // aileron
		5'b01000,   // elevator
		5'b00010,   // throttle
		5'b10000,   // rudder
		5'b00001    // althold
	};

	// reciprocal divide by TICKS_PER_MICROSECOND; exact for every delta below SAT_LIMIT
	localparam logic [63:0] SAT_LIMIT = 64'd65536 * 64'(TICKS_PER_MICROSECOND);
	localparam int DELTA_BITS = $clog2(SAT_LIMIT);
	localparam int SHIFT_BITS = $clog2(TICKS_PER_MICROSECOND);
	localparam int RECIP_SHIFT = DELTA_BITS + SHIFT_BITS;
	localparam logic [63:0] RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(TICKS_PER_MICROSECOND) - 64'd1)
		/ 64'(TICKS_PER_MICROSECOND);
	localparam int PROD_BITS = RECIP_SHIFT + WIDTH_BITS;

	typedef struct packed {
		logic [PIN_BITS-1:0]  pin_levels;
		logic [PIN_BITS-1:0]  edge_flags;
		logic [TICK_BITS-1:0] tick_count;
	} rcpw_in_t;

	typedef struct packed {
		logic [CH_BITS-1:0]    channel;
		logic [WIDTH_BITS-1:0] pulse_width_us;
	} rcpw_out_t;

endpackage

>>> sv/rcpw_width.sv
`timescale 1ns / 1ps

module rcpw_width import rcpw_pkg::*; (
	input  logic [TICK_BITS-1:0]  delta,
	output logic [WIDTH_BITS-1:0] width_us
);

	logic [DELTA_BITS-1:0] delta_nar;
	logic [PROD_BITS-1:0]  prod;

	assign delta_nar = delta[DELTA_BITS-1:0];
	assign prod = PROD_BITS'(delta_nar) * PROD_BITS'(RECIP);

	// at or above the limit the quotient would exceed 16 bits
	always_comb begin
		if (64'(delta) >= SAT_LIMIT) begin
			width_us = WIDTH_MAX;
		end else begin
			width_us = prod[RECIP_SHIFT +: WIDTH_BITS];
		end
	end

endmodule

>>> sv/rc_pwm_pulse_width_capture_core.sv
`timescale 1ns / 1ps
// RC receiver pulse-width capture, five channels.
// Throughput: one pin-change request per clock, sustained while results are not held.
// Path: a taken request is captured in the input register, and its result is then
// computed into the output register, where it is valid for handoff.
// Stalls: a request with a result waits in the input register while the output is held.
// Reset: no channel active; start times hold garbage until a channel starts.

module rc_pwm_pulse_width_capture_core import rcpw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,

	input  logic      pin_valid,
	output logic      pin_stall,
	input  rcpw_in_t  pin_data,

	output logic      pulse_valid,
	input  logic      pulse_stall,
	output rcpw_out_t pulse_data
);

	// input register
	logic     valid_s1;
	rcpw_in_t req_s1;

	// channel state
	logic [CH_BITS-1:0]   active_q;
	logic [TICK_BITS-1:0] start_q [NUM_LINES];

	// output register
	logic      pulse_valid_q;
	rcpw_out_t pulse_q;

	logic                  hit;
	logic [CH_BITS-1:0]    hit_idx;
	logic                  active_ok;
	logic [CH_BITS-1:0]    act_idx;
	logic                  flag_set;
	logic                  has_result;
	logic                  out_free;
	logic                  s1_go;
	logic [TICK_BITS-1:0]  delta;
	logic [WIDTH_BITS-1:0] width_us;

	// Priority pick: walk from lowest priority up so the first high pin wins.
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int k = USED_CHANNELS - 1; k >= 0; k--) begin
			if ((req_s1.pin_levels & CHAN_MASK[k]) != '0) begin
				hit = 1'b1;
				hit_idx = CH_BITS'(k);
			end
		end
	end

	// codes at or past the used channel count mean nothing active
	assign active_ok = (32'(active_q) < USED_CHANNELS);
	assign act_idx = active_ok ? active_q : '0;
	assign flag_set = active_ok && ((req_s1.edge_flags & CHAN_MASK[act_idx]) != '0);
	assign has_result = !hit && flag_set;

	// wraps modulo 2^32, so one counter rollover per pulse is fine
	assign delta = req_s1.tick_count - start_q[act_idx];

	rcpw_width u_width (
		.delta    (delta),
		.width_us (width_us)
	);

	// An item that makes no result never waits on the output side.
	assign out_free = !pulse_valid_q || !pulse_stall;
	assign s1_go = valid_s1 && (!has_result || out_free);
	assign pin_stall = valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pin_stall) begin
			valid_s1 <= pin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pin_valid && !pin_stall) begin
			req_s1 <= pin_data;
		end
	end

	// Any event with no pin high ends the active pulse, result or not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= NO_CHANNEL;
		end else if (s1_go) begin
			if (hit) begin
				active_q <= hit_idx;
			end else begin
				active_q <= NO_CHANNEL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && hit) begin
			start_q[hit_idx] <= req_s1.tick_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_valid_q <= 1'b0;
		end else if (s1_go && has_result) begin
			pulse_valid_q <= 1'b1;
		end else if (!pulse_stall) begin
			pulse_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && has_result) begin
			pulse_q.channel <= act_idx;
			pulse_q.pulse_width_us <= width_us;
		end
	end

	assign pulse_valid = pulse_valid_q;
	assign pulse_data = pulse_q;

endmodule
